/* hdl/assert_macros.svh */
// Assertion macros used by the top level of the epipolar inlier scorer.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Consequent must hold in the same cycle as the antecedent.
`define EIS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define EIS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define EIS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define EIS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* hdl/eis_pkg.sv */
// Widths, register codes and reset values of the epipolar inlier scorer.
// No dependencies; used by epipolar_inlier_score.
package eis_pkg;
    localparam int COORD_W      = 16;
    localparam int ENTRY_W      = 16;
    localparam int ROW_W        = 3 * ENTRY_W;
    localparam int LINE_W       = 33;
    localparam int SQ_W         = 64;
    localparam int NSQ_W        = 65;
    localparam int DOT_W        = 49;
    localparam int MAG_W        = 48;
    localparam int HALF_W       = MAG_W / 2;
    localparam int DSQ_W        = 2 * MAG_W;
    localparam int FRAC_BITS    = 12;
    localparam int TERM_CAP_LOG = 20;
    localparam int DIST_DEN_W   = NSQ_W + FRAC_BITS;
    localparam int DIST_W       = DIST_DEN_W + TERM_CAP_LOG;
    localparam int TERM_W       = TERM_CAP_LOG + 1;
    localparam int SUM_W        = TERM_W + 1;
    localparam int THR_W        = 16;
    localparam int T2_W         = 2 * THR_W;
    localparam int SCORE_W      = 16;
    localparam int SCORE_NUM_W  = T2_W + SCORE_W;
    localparam int ERR_W        = 16;
    localparam int SCORE_SIDE_W = ERR_W + 2;
    localparam int CFG_IDX_W    = 2;

    localparam logic [THR_W-1:0] THR_RESET = 16'd4096;
    localparam logic [ERR_W-1:0] ERR_SAT   = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_TOP    = 2'd0,
        CFG_ROW_MID    = 2'd1,
        CFG_ROW_BOTTOM = 2'd2,
        CFG_THRESHOLD  = 2'd3
    } t_cfg_idx;

    // a*x + b*y + c*4096 at line scale
    function automatic logic signed [LINE_W-1:0] line_eval(
        input logic signed [ENTRY_W-1:0] a,
        input logic signed [ENTRY_W-1:0] b,
        input logic signed [ENTRY_W-1:0] c,
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y);
        logic signed [LINE_W-1:0] ea, eb, ec, ex, ey;
        ea = LINE_W'(a);
        eb = LINE_W'(b);
        ec = LINE_W'(c);
        ex = LINE_W'(x);
        ey = LINE_W'(y);
        return ea * ex + eb * ey + (ec <<< FRAC_BITS);
    endfunction
endpackage

/* hdl/eis_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on nothing; the numerator must be below den << Q_W.
module eis_div #(
    parameter int DEN_W  = 32,
    parameter int Q_W    = 16,
    parameter int SIDE_W = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [DEN_W+Q_W-1:0]   i_num,
    input  logic [DEN_W-1:0]       i_den,
    input  logic [SIDE_W-1:0]      i_side,
    output logic                   o_valid,
    output logic [Q_W-1:0]         o_q,
    output logic [SIDE_W-1:0]      o_side
);
    localparam int W = DEN_W + Q_W;

    logic [W-1:0]      r_rem  [Q_W];
    logic [DEN_W-1:0]  r_den  [Q_W];
    logic [Q_W-1:0]    r_q    [Q_W];
    logic [SIDE_W-1:0] r_side [Q_W];
    logic [Q_W-1:0]    r_vld;

    logic [W-1:0]      src_rem  [Q_W];
    logic [DEN_W-1:0]  src_den  [Q_W];
    logic [Q_W-1:0]    src_q    [Q_W];
    logic [SIDE_W-1:0] src_side [Q_W];
    logic [Q_W-1:0]    src_vld;
    logic [W-1:0]      trial    [Q_W];
    logic [W-1:0]      n_rem    [Q_W];
    logic [Q_W-1:0]    n_q      [Q_W];

    always_comb begin
        for (int k = 0; k < Q_W; k++) begin
            if (k == 0) begin
                src_rem[k]  = i_num;
                src_den[k]  = i_den;
                src_q[k]    = '0;
                src_side[k] = i_side;
                src_vld[k]  = i_valid;
            end else begin
                src_rem[k]  = r_rem[k-1];
                src_den[k]  = r_den[k-1];
                src_q[k]    = r_q[k-1];
                src_side[k] = r_side[k-1];
                src_vld[k]  = r_vld[k-1];
            end
            // try the divisor at the weight of this stage's bit
            trial[k] = {{Q_W{1'b0}}, src_den[k]} << (Q_W - 1 - k);
            n_rem[k] = src_rem[k];
            n_q[k]   = src_q[k];
            if (src_rem[k] >= trial[k]) begin
                n_rem[k] = src_rem[k] - trial[k];
                n_q[k][Q_W-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= src_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < Q_W; k++) begin
                r_rem[k]  <= n_rem[k];
                r_den[k]  <= src_den[k];
                r_q[k]    <= n_q[k];
                r_side[k] <= src_side[k];
            end
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_q     = r_q[Q_W-1];
    assign o_side  = r_side[Q_W-1];
endmodule

/* hdl/epipolar_inlier_score.sv */
// Top level of the epipolar inlier scorer: line forming, distances, score.
// Depends on eis_pkg, eis_div and assert_macros.svh.
//
// Use: load the three rows of the essential matrix and the threshold through
// the write port (i_cfg_we, i_cfg_index, i_cfg_data) while no beat is in
// flight. Point pairs enter on i_in_valid / o_in_ready; one result beat per
// pair leaves on o_out_valid / i_out_ready, in order.
// Throughput: one beat per cycle unless the receiver stalls. An accepted input
// beat reaches its result through seven arithmetic stages, the 20-bit distance
// divider (one quotient bit per stage), three score stages, the 16-bit score
// divider and the output register.
// Reset clears every valid bit, zeroes the matrix rows and sets the threshold
// to 1.0 (code 4096). When the receiver stalls with a result waiting, the
// whole pipeline holds and o_in_ready drops; nothing is lost or repeated,
// and bubbles in the stream travel as empty slots.
`include "assert_macros.svh"
module epipolar_inlier_score (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [eis_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [eis_pkg::ROW_W-1:0]             i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [eis_pkg::COORD_W-1:0]    i_first_x,
    input  logic signed [eis_pkg::COORD_W-1:0]    i_first_y,
    input  logic signed [eis_pkg::COORD_W-1:0]    i_second_x,
    input  logic signed [eis_pkg::COORD_W-1:0]    i_second_y,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [eis_pkg::SCORE_W-1:0]           o_score,
    output logic [eis_pkg::ERR_W-1:0]             o_error_sum,
    output logic                                  o_degenerate
);
    localparam int LW = eis_pkg::LINE_W;
    localparam int DW = eis_pkg::DOT_W;
    localparam int MW = eis_pkg::MAG_W;
    localparam int HW = eis_pkg::HALF_W;
    localparam int PW = 2 * HW;

    // configuration
    logic [eis_pkg::ROW_W-1:0] r_row [3];
    logic [eis_pkg::THR_W-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= '0;
            r_row[1] <= '0;
            r_row[2] <= '0;
            r_thr    <= eis_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            case (eis_pkg::t_cfg_idx'(i_cfg_index))
                eis_pkg::CFG_ROW_TOP:    r_row[0] <= i_cfg_data;
                eis_pkg::CFG_ROW_MID:    r_row[1] <= i_cfg_data;
                eis_pkg::CFG_ROW_BOTTOM: r_row[2] <= i_cfg_data;
                eis_pkg::CFG_THRESHOLD:  r_thr    <= i_cfg_data[eis_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    logic signed [eis_pkg::ENTRY_W-1:0] e [3][3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                e[i][j] = r_row[i][16*j +: 16];
            end
        end
    end

    // global advance: hold everything while a result waits unread
    logic en;
    logic r_out_vld;
    assign en         = !r_out_vld || i_out_ready;
    assign o_in_ready = en;

    // stage A: lines l = E*p2 and m = E^T*p1
    logic                    r_a_vld;
    logic signed [LW-1:0]    r_l [3];
    logic signed [LW-1:0]    r_m [3];
    logic signed [eis_pkg::COORD_W-1:0] r_p1x, r_p1y, r_p2x, r_p2y;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_l[i] <= eis_pkg::line_eval(e[i][0], e[i][1], e[i][2],
                                             i_second_x, i_second_y);
                r_m[i] <= eis_pkg::line_eval(e[0][i], e[1][i], e[2][i],
                                             i_first_x, i_first_y);
            end
            r_p1x <= i_first_x;
            r_p1y <= i_first_y;
            r_p2x <= i_second_x;
            r_p2y <= i_second_y;
        end
    end

    // stage B: normal squares and point products
    logic signed [eis_pkg::SQ_W-1:0] b_lx, b_ly, b_mx, b_my;
    logic signed [DW-1:0] b_l0, b_l1, b_m0, b_m1;
    logic signed [DW-1:0] b_p1x, b_p1y, b_p2x, b_p2y;
    always_comb begin
        b_lx  = eis_pkg::SQ_W'(r_l[0]);
        b_ly  = eis_pkg::SQ_W'(r_l[1]);
        b_mx  = eis_pkg::SQ_W'(r_m[0]);
        b_my  = eis_pkg::SQ_W'(r_m[1]);
        b_l0  = DW'(r_l[0]);
        b_l1  = DW'(r_l[1]);
        b_m0  = DW'(r_m[0]);
        b_m1  = DW'(r_m[1]);
        b_p1x = DW'(r_p1x);
        b_p1y = DW'(r_p1y);
        b_p2x = DW'(r_p2x);
        b_p2y = DW'(r_p2y);
    end

    logic                          r_b_vld;
    logic [eis_pkg::SQ_W-1:0]      r_lsq0, r_lsq1, r_msq0, r_msq1;
    logic signed [DW-1:0]          r_ldp0, r_ldp1, r_mdp0, r_mdp1;
    logic signed [LW-1:0]          r_l2, r_m2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lsq0 <= b_lx * b_lx;
            r_lsq1 <= b_ly * b_ly;
            r_msq0 <= b_mx * b_mx;
            r_msq1 <= b_my * b_my;
            r_ldp0 <= b_l0 * b_p1x;
            r_ldp1 <= b_l1 * b_p1y;
            r_mdp0 <= b_m0 * b_p2x;
            r_mdp1 <= b_m1 * b_p2y;
            r_l2   <= r_l[2];
            r_m2   <= r_m[2];
        end
    end

    // stage C: normal norms and dot products
    logic                           r_c_vld;
    logic [eis_pkg::NSQ_W-1:0]      r_c_nl, r_c_nm;
    logic signed [DW-1:0]           r_dl, r_dm;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_nl <= eis_pkg::NSQ_W'(r_lsq0) + eis_pkg::NSQ_W'(r_lsq1);
            r_c_nm <= eis_pkg::NSQ_W'(r_msq0) + eis_pkg::NSQ_W'(r_msq1);
            r_dl   <= r_ldp0 + r_ldp1 + (DW'(r_l2) <<< eis_pkg::FRAC_BITS);
            r_dm   <= r_mdp0 + r_mdp1 + (DW'(r_m2) <<< eis_pkg::FRAC_BITS);
        end
    end

    // stage D: zero-normal flag and dot magnitudes
    logic                       r_d_vld, r_d_deg;
    logic [eis_pkg::NSQ_W-1:0]  r_d_nl, r_d_nm;
    logic [MW-1:0]              r_dlm, r_dmm;
    logic signed [DW-1:0]       d_dl_neg, d_dm_neg;
    assign d_dl_neg = -r_dl;
    assign d_dm_neg = -r_dm;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_deg <= (r_c_nl == '0) || (r_c_nm == '0);
            r_d_nl  <= r_c_nl;
            r_d_nm  <= r_c_nm;
            r_dlm   <= r_dl[DW-1] ? d_dl_neg[MW-1:0] : r_dl[MW-1:0];
            r_dmm   <= r_dm[DW-1] ? d_dm_neg[MW-1:0] : r_dm[MW-1:0];
        end
    end

    // stage E: partial products of the squared dots
    logic                       r_e_vld, r_e_deg;
    logic [eis_pkg::NSQ_W-1:0]  r_e_nl, r_e_nm;
    logic [PW-1:0]              r_lhh, r_lhl, r_lll, r_mhh, r_mhl, r_mll;
    logic [PW-1:0]              e_lh, e_ll, e_mh, e_ml;
    assign e_lh = PW'(r_dlm[MW-1:HW]);
    assign e_ll = PW'(r_dlm[HW-1:0]);
    assign e_mh = PW'(r_dmm[MW-1:HW]);
    assign e_ml = PW'(r_dmm[HW-1:0]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_deg <= r_d_deg;
            r_e_nl  <= r_d_nl;
            r_e_nm  <= r_d_nm;
            r_lhh   <= e_lh * e_lh;
            r_lhl   <= e_lh * e_ll;
            r_lll   <= e_ll * e_ll;
            r_mhh   <= e_mh * e_mh;
            r_mhl   <= e_mh * e_ml;
            r_mll   <= e_ml * e_ml;
        end
    end

    // stage F: assemble squared dots
    logic                       r_f_vld, r_f_deg;
    logic [eis_pkg::NSQ_W-1:0]  r_f_nl, r_f_nm;
    logic [eis_pkg::DSQ_W-1:0]  r_ldsq, r_mdsq;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_deg <= r_e_deg;
            r_f_nl  <= r_e_nl;
            r_f_nm  <= r_e_nm;
            r_ldsq  <= (eis_pkg::DSQ_W'(r_lhh) << PW) + (eis_pkg::DSQ_W'(r_lhl) << (HW + 1))
                     + eis_pkg::DSQ_W'(r_lll);
            r_mdsq  <= (eis_pkg::DSQ_W'(r_mhh) << PW) + (eis_pkg::DSQ_W'(r_mhl) << (HW + 1))
                     + eis_pkg::DSQ_W'(r_mll);
        end
    end

    // stage G: cap check, then feed the distance dividers
    logic [eis_pkg::DIST_DEN_W-1:0] g_den_l, g_den_m;
    logic [eis_pkg::DIST_W-1:0]     g_num_l, g_num_m, g_cap_l, g_cap_m;
    logic                           g_sat_l, g_sat_m;
    always_comb begin
        g_den_l = {r_f_nl, {eis_pkg::FRAC_BITS{1'b0}}};
        g_den_m = {r_f_nm, {eis_pkg::FRAC_BITS{1'b0}}};
        g_cap_l = {g_den_l, {eis_pkg::TERM_CAP_LOG{1'b0}}};
        g_cap_m = {g_den_m, {eis_pkg::TERM_CAP_LOG{1'b0}}};
        g_num_l = eis_pkg::DIST_W'(r_ldsq);
        g_num_m = eis_pkg::DIST_W'(r_mdsq);
        g_sat_l = g_num_l >= g_cap_l;
        g_sat_m = g_num_m >= g_cap_m;
    end

    logic                           r_g_vld, r_g_deg, r_g_sat_l, r_g_sat_m;
    logic [eis_pkg::DIST_W-1:0]     r_g_num_l, r_g_num_m;
    logic [eis_pkg::DIST_DEN_W-1:0] r_g_den_l, r_g_den_m;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_deg   <= r_f_deg;
            r_g_sat_l <= g_sat_l;
            r_g_sat_m <= g_sat_m;
            // drop a capped term to zero so the divider precondition holds
            r_g_num_l <= g_sat_l ? '0 : g_num_l;
            r_g_num_m <= g_sat_m ? '0 : g_num_m;
            r_g_den_l <= g_den_l;
            r_g_den_m <= g_den_m;
        end
    end

    logic                              dl_vld, dm_vld;
    logic [eis_pkg::TERM_CAP_LOG-1:0]  dl_q, dm_q;
    logic [1:0]                        dl_side;
    logic                              dm_side;

    eis_div #(
        .DEN_W (eis_pkg::DIST_DEN_W),
        .Q_W   (eis_pkg::TERM_CAP_LOG),
        .SIDE_W(2)
    ) u_div_l (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(r_g_vld),
        .i_num  (r_g_num_l),
        .i_den  (r_g_den_l),
        .i_side ({r_g_deg, r_g_sat_l}),
        .o_valid(dl_vld),
        .o_q    (dl_q),
        .o_side (dl_side)
    );

    eis_div #(
        .DEN_W (eis_pkg::DIST_DEN_W),
        .Q_W   (eis_pkg::TERM_CAP_LOG),
        .SIDE_W(1)
    ) u_div_m (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(r_g_vld),
        .i_num  (r_g_num_m),
        .i_den  (r_g_den_m),
        .i_side (r_g_sat_m),
        .o_valid(dm_vld),
        .o_q    (dm_q),
        .o_side (dm_side)
    );

    // stage H: sum of capped terms
    logic [eis_pkg::TERM_W-1:0] h_term_l, h_term_m;
    assign h_term_l = dl_side[0] ? eis_pkg::TERM_W'(1) << eis_pkg::TERM_CAP_LOG
                                 : eis_pkg::TERM_W'(dl_q);
    assign h_term_m = dm_side ? eis_pkg::TERM_W'(1) << eis_pkg::TERM_CAP_LOG
                              : eis_pkg::TERM_W'(dm_q);

    logic                        r_h_vld, r_h_deg;
    logic [eis_pkg::SUM_W-1:0]   r_h_s;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_deg <= dl_side[1];
            r_h_s   <= eis_pkg::SUM_W'(h_term_l) + eis_pkg::SUM_W'(h_term_m);
        end
    end

    // stage I: compare against threshold squared
    logic [eis_pkg::T2_W-1:0]          i_t2;
    logic [eis_pkg::SUM_W+11:0]        i_s12;
    assign i_t2  = eis_pkg::T2_W'(r_thr) * eis_pkg::T2_W'(r_thr);
    assign i_s12 = {r_h_s, {eis_pkg::FRAC_BITS{1'b0}}};

    logic                        r_i_vld, r_i_deg, r_i_zero;
    logic [eis_pkg::T2_W-1:0]    r_i_t2, r_i_diff;
    logic [eis_pkg::ERR_W-1:0]   r_i_err;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i_deg  <= r_h_deg;
            r_i_zero <= r_h_deg || (i_s12 >= (eis_pkg::SUM_W+12)'(i_t2));
            r_i_t2   <= i_t2;
            r_i_diff <= i_t2 - i_s12[eis_pkg::T2_W-1:0];
            if (r_h_deg || (r_h_s > eis_pkg::SUM_W'(eis_pkg::ERR_SAT))) begin
                r_i_err <= eis_pkg::ERR_SAT;
            end else begin
                r_i_err <= r_h_s[eis_pkg::ERR_W-1:0];
            end
        end
    end

    // stage J: scale the margin by 65535
    logic                               r_j_vld, r_j_deg, r_j_zero;
    logic [eis_pkg::T2_W-1:0]           r_j_t2;
    logic [eis_pkg::SCORE_NUM_W-1:0]    r_j_num;
    logic [eis_pkg::ERR_W-1:0]          r_j_err;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_j_deg  <= r_i_deg;
            r_j_zero <= r_i_zero;
            r_j_t2   <= r_i_t2;
            r_j_err  <= r_i_err;
            r_j_num  <= {r_i_diff, {eis_pkg::SCORE_W{1'b0}}}
                      - eis_pkg::SCORE_NUM_W'(r_i_diff);
        end
    end

    logic                               ds_vld;
    logic [eis_pkg::SCORE_W-1:0]        ds_q;
    logic [eis_pkg::SCORE_SIDE_W-1:0]   ds_side;

    eis_div #(
        .DEN_W (eis_pkg::T2_W),
        .Q_W   (eis_pkg::SCORE_W),
        .SIDE_W(eis_pkg::SCORE_SIDE_W)
    ) u_div_score (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(r_j_vld),
        .i_num  (r_j_num),
        .i_den  (r_j_t2),
        .i_side ({r_j_deg, r_j_zero, r_j_err}),
        .o_valid(ds_vld),
        .o_q    (ds_q),
        .o_side (ds_side)
    );

    // output register
    logic [eis_pkg::SCORE_W-1:0] r_score;
    logic [eis_pkg::ERR_W-1:0]   r_err;
    logic                        r_deg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_score <= ds_side[eis_pkg::ERR_W] ? '0 : ds_q;
            r_err   <= ds_side[eis_pkg::ERR_W-1:0];
            r_deg   <= ds_side[eis_pkg::ERR_W+1];
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_e_vld   <= 1'b0;
            r_f_vld   <= 1'b0;
            r_g_vld   <= 1'b0;
            r_h_vld   <= 1'b0;
            r_i_vld   <= 1'b0;
            r_j_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_a_vld   <= i_in_valid;
            r_b_vld   <= r_a_vld;
            r_c_vld   <= r_b_vld;
            r_d_vld   <= r_c_vld;
            r_e_vld   <= r_d_vld;
            r_f_vld   <= r_e_vld;
            r_g_vld   <= r_f_vld;
            r_h_vld   <= dl_vld;
            r_i_vld   <= r_h_vld;
            r_j_vld   <= r_i_vld;
            r_out_vld <= ds_vld;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_score      = r_score;
    assign o_error_sum  = r_err;
    assign o_degenerate = r_deg;

    // the two distance dividers must stay in lockstep
    `EIS_ASSERT_IMP(a_div_lockstep, i_clk, i_rst_n, 1'b1, dl_vld == dm_vld)
    // a zero normal forces the saturated result
    `EIS_ASSERT_IMP(a_degenerate_sat, i_clk, i_rst_n, o_out_valid && o_degenerate,
        (o_score == '0) && (o_error_sum == eis_pkg::ERR_SAT))
    // a nonzero score implies the error lies inside the threshold
    `EIS_ASSERT_IMP(a_score_inside, i_clk, i_rst_n, o_out_valid && (o_score != '0),
        ({4'b0, o_error_sum, 12'b0} < (eis_pkg::T2_W'(r_thr) * eis_pkg::T2_W'(r_thr))))
    // an accepted beat lands in the first stage
    `EIS_ASSERT_NXT(a_accept_lands, i_clk, i_rst_n, i_in_valid && o_in_ready, r_a_vld)
endmodule
